// File: rtl/core/fof_pkg.sv
// Shared constants and types for the first-occurrence filter.
`default_nettype none
package fof_pkg;

   // Number of cells in the chain, which is the number of distinct values one set can record.
   localparam int unsigned FOF_DEPTH = 128;
   localparam int unsigned FOF_VALUE_WIDTH = 32;

   typedef logic signed [FOF_VALUE_WIDTH-1:0] fof_value_type;

   // Item traveling down the chain, together with the verdict it has gathered so far.
   typedef struct packed {
      logic          valid;
      logic          clear;
      logic          dup;
      logic          placed;
      fof_value_type value;
   } fof_item_type;

endpackage
`default_nettype wire

// File: rtl/core/fof_stream_if.sv
// Valid/ready channel interfaces for the filter's request and response streams.
`default_nettype none
interface fof_req_if import fof_pkg::*; ();
   logic          valid;
   logic          ready;
   logic          start_of_set;
   fof_value_type value;

   modport source (output valid, output start_of_set, output value, input ready);
   modport sink (input valid, input start_of_set, input value, output ready);
endinterface

interface fof_rsp_if import fof_pkg::*; ();
   logic          valid;
   logic          ready;
   fof_value_type unique_value;
   logic          overflow;

   modport source (output valid, output unique_value, output overflow, input ready);
   modport sink (input valid, input unique_value, input overflow, output ready);
endinterface
`default_nettype wire

// File: rtl/core/fof_cell.sv
// One storage cell of the chain: holds one recorded value and checks passing items against it.
`default_nettype none
module fof_cell import fof_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         advance,
   input  wire fof_item_type item_i,
   output fof_item_type      item_o,
   output logic              held_valid
);

   logic          valid_ff, valid_in;
   fof_value_type value_ff, value_in;
   fof_item_type  item_ff, item_in;
   logic          kept_valid;
   logic          match;
   logic          store;

   always_comb begin
      // A start-of-set item empties the cell before it is compared.
      kept_valid = valid_ff & ~(item_i.valid & item_i.clear);
      match      = item_i.valid & kept_valid & (value_ff == item_i.value);
      store      = item_i.valid & ~item_i.dup & ~item_i.placed & ~kept_valid;

      valid_in = kept_valid | store;
      value_in = store ? item_i.value : value_ff;

      item_in        = item_i;
      item_in.dup    = item_i.dup | (match & ~item_i.placed);
      item_in.placed = item_i.placed | store;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff      <= 1'b0;
         item_ff.valid <= 1'b0;
      end else if (advance) begin
         valid_ff <= valid_in;
         item_ff  <= item_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         value_ff <= value_in;
      end
   end

   assign item_o     = item_ff;
   assign held_valid = valid_ff;

endmodule
`default_nettype wire

// File: rtl/core/first_occurrence_filter_core.sv
// Top level of the first-occurrence filter: a chain of compare-and-store cells and an output register.
// A request's item is loaded into the first cell's register by its transfer edge, passes through each further
// cell's register in turn and then the output register; only a first occurrence yields a response. Throughput: one
// request per cycle while responses are taken; the whole chain stalls only while a response waits
// and rsp_if.ready is low.
// Reset clears every cell's valid bit, the valid bit of each item in flight and that of the response register.
`default_nettype none
module first_occurrence_filter_core import fof_pkg::*; (
   input  wire logic clock,
   input  wire logic reset,
   fof_req_if.sink   req_if,
   fof_rsp_if.source rsp_if
);

   fof_item_type                chain [FOF_DEPTH+1];
   logic         [FOF_DEPTH-1:0] cell_valid;
   logic                         advance;
   fof_item_type                 tail;

   logic          rsp_valid_ff;
   fof_value_type rsp_value_ff;
   logic          rsp_overflow_ff;

   assign advance = ~rsp_valid_ff | rsp_if.ready;
   assign req_if.ready = advance;

   always_comb begin
      chain[0].valid  = req_if.valid;
      chain[0].clear  = req_if.start_of_set;
      chain[0].dup    = 1'b0;
      chain[0].placed = 1'b0;
      chain[0].value  = req_if.value;
   end

   for (genvar k = 0; k < FOF_DEPTH; k++) begin : g_cell
      fof_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .advance    (advance),
         .item_i     (chain[k]),
         .item_o     (chain[k+1]),
         .held_valid (cell_valid[k])
      );
   end

   assign tail = chain[FOF_DEPTH];

   // An item leaving the chain unplaced and not a repeat found the store full.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= tail.valid & ~tail.dup;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_value_ff    <= tail.value;
         rsp_overflow_ff <= ~tail.placed;
      end
   end

   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.unique_value = rsp_value_ff;
   assign rsp_if.overflow     = rsp_overflow_ff;

   // A waiting response keeps its payload until it is taken.
   a_rsp_hold : assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && !rsp_if.ready |=>
         rsp_if.valid && $stable(rsp_if.unique_value) && $stable(rsp_if.overflow))
      else $error("response changed while waiting");

   a_reset_empty : assert property (@(posedge clock)
      reset |=> (cell_valid == '0) && !rsp_valid_ff)
      else $error("store or response not empty after reset");

   a_stall_hold : assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(cell_valid) && $stable(tail))
      else $error("chain moved while stalled");

endmodule
`default_nettype wire
